FILE: src/sha1_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-1 byte stream hasher checker.
// Expects clk and arst_n in the scope of use; needs nothing else.
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SBH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbh assertion failed");

// next-cycle implication
`define SBH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbh assertion failed");

`endif

FILE: src/sbh_pkg.sv
// Shared types and constants of the SHA-1 byte stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package sbh_pkg;

	localparam int DIGEST_WORDS = 5;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_END = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] POS_LEN    = 6'd56;
	localparam logic [5:0] POS_LAST   = 6'd63;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] ROUND_PAR  = 7'd20;
	localparam logic [6:0] ROUND_MAJ  = 7'd40;
	localparam logic [6:0] ROUND_END  = 7'd60;
	localparam logic [2:0] LEN_LAST   = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_HOLD
	} state_t;

	typedef enum logic [1:0] {
		PH_80,
		PH_ZERO,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		SEL_INPUT,
		SEL_PAD80,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef enum logic [1:0] {
		STG_CH,
		STG_PAR,
		STG_MAJ,
		STG_END
	} stage_t;

	typedef struct packed {
		logic      absorb;
		logic      count;
		byte_sel_t sel;
		logic [2:0] len_idx;
		logic      round;
		stage_t    stage;
		logic      add;
		logic      finish;
	} sbh_cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_at56;
		logic out_free;
	} sbh_stat_t;

endpackage

`default_nettype wire

FILE: src/sbh_channels.sv
// Handshake channels of the hasher: byte input beats and digest output beats.
// Depends on nothing.
`default_nettype none

interface sbh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sbh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;

	modport source (output valid, digest_word, word_number, last_word, input ready);
	modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

`default_nettype wire

FILE: src/sbh_ctrl.sv
// Controller of the hasher: sequences byte absorb, padding, rounds and digest hand-off.
// Depends on sbh_pkg.
`default_nettype none

module sbh_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_byte_present,
	input  wire logic          in_eom,
	output logic               in_ready,
	input  wire sbh_pkg::sbh_stat_t stat,
	output sbh_pkg::sbh_cmd_t  cmd
);
	import sbh_pkg::*;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [2:0] idx_q, idx_d;
	logic [6:0] rnd_q, rnd_d;
	logic       fin_q, fin_d;
	logic       done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_80;
			idx_q   <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
			rnd_q   <= rnd_d;
			fin_q   <= fin_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		idx_d    = idx_q;
		rnd_d    = rnd_q;
		fin_d    = fin_q;
		done_d   = done_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					fin_d = in_eom;
					if (in_byte_present) begin
						cmd.absorb = 1'b1;
						cmd.count  = 1'b1;
						cmd.sel    = SEL_INPUT;
					end
					if (in_byte_present && stat.pos_last) begin
						state_d = ST_ROUND;
					end else if (in_eom) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.absorb = 1'b1;
				if (phase_q == PH_80) begin
					cmd.sel = SEL_PAD80;
					phase_d = PH_ZERO;
				end else if (phase_q == PH_ZERO && !stat.pos_at56) begin
					cmd.sel = SEL_ZERO;
				end else begin
					cmd.sel     = SEL_LEN;
					cmd.len_idx = idx_q;
					phase_d     = PH_LEN;
					idx_d       = idx_q + 3'd1;
					if (idx_q == LEN_LAST) begin
						done_d = 1'b1;
					end
				end
				if (stat.pos_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q < ROUND_PAR) begin
					cmd.stage = STG_CH;
				end else if (rnd_q < ROUND_MAJ) begin
					cmd.stage = STG_PAR;
				end else if (rnd_q < ROUND_END) begin
					cmd.stage = STG_MAJ;
				end else begin
					cmd.stage = STG_END;
				end
				rnd_d = rnd_q + 7'd1;
				if (rnd_q == ROUND_LAST) begin
					rnd_d   = '0;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (done_q) begin
					state_d = ST_HOLD;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					fin_d      = 1'b0;
					done_d     = 1'b0;
					phase_d    = PH_80;
					idx_d      = '0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/sbh_datapath.sv
// Datapath of the hasher: block window, round unit, chaining words, bit count, digest buffer.
// Depends on sbh_pkg; driven by sbh_ctrl.
`default_nettype none

module sbh_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    in_byte,
	input  wire sbh_pkg::sbh_cmd_t cmd,
	output sbh_pkg::sbh_stat_t stat,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_number,
	output logic               last_word
);
	import sbh_pkg::*;

	// block window: word i of the window sits at [511-32*i -: 32]
	logic [511:0]      blk_q;
	logic [4:0][31:0]  chain_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [5:0]        pos_q;
	logic [63:0]       bits_q;
	logic [4:0][31:0]  out_q;
	logic [2:0]        cnt_q;

	logic [7:0]  byte_mux;
	logic [5:0]  len_ofs;
	logic [31:0] w_new;
	logic [31:0] w_mix;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] a_next;
	logic        take;

	assign len_ofs = {~cmd.len_idx, 3'b000};

	always_comb begin
		case (cmd.sel)
			SEL_INPUT: byte_mux = in_byte;
			SEL_PAD80: byte_mux = PAD_BYTE;
			SEL_ZERO:  byte_mux = 8'h00;
			SEL_LEN:   byte_mux = bits_q[len_ofs +: 8];
			default:   byte_mux = 8'h00;
		endcase
	end

	// rolling schedule: w[t+16] from window words 13, 8, 2, 0
	assign w_mix = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_comb begin
		case (cmd.stage)
			STG_CH: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = K_CH;
			end
			STG_PAR: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_PAR;
			end
			STG_MAJ: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K_MAJ;
			end
			STG_END: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_END;
			end
			default: begin
				f_val = '0;
				k_val = '0;
			end
		endcase
	end

	assign a_next = {a_q[26:0], a_q[31:27]} + f_val + e_q + blk_q[511:480] + k_val;

	// window and working variables carry no reset
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			blk_q <= {blk_q[503:0], byte_mux};
			if (pos_q == POS_LAST) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
			a_q   <= a_next;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= chain_q;
		end else if (take) begin
			out_q <= {32'h0, out_q[4:1]};
		end
	end

	assign take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
			pos_q   <= '0;
			bits_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.absorb) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.finish) begin
				chain_q <= H_INIT;
				bits_q  <= '0;
				cnt_q   <= 3'(DIGEST_WORDS);
			end else if (take) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	assign stat.pos_last = (pos_q == POS_LAST);
	assign stat.pos_at56 = (pos_q == POS_LEN);
	assign stat.out_free = (cnt_q == 3'd0);

	assign out_valid   = (cnt_q != 3'd0);
	assign digest_word = out_q[0];
	assign word_number = 3'(DIGEST_WORDS) - cnt_q;
	assign last_word   = (cnt_q == 3'd1);

endmodule

`default_nettype wire

FILE: src/sha1_byte_stream_hasher.sv
// SHA-1 hasher, one message byte per beat. The 64th byte of a block then starts
// 80 rounds, one per cycle, then the chaining add; no byte is taken meanwhile.
// End beat: one padding byte per cycle plus one or two compressions and the buffer hand-off,
// then five digest beats from a buffer; input is taken again while the digest drains.
// Reset (arst_n low, asynchronous): initial chaining words, byte and bit counts zero,
// digest buffer empty; the block window is not reset.
`default_nettype none

module sha1_byte_stream_hasher (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sbh_byte_if.sink     bytes,
	sbh_digest_if.source digest
);
	import sbh_pkg::*;

	// command and status between the sequencer and the datapath
	sbh_cmd_t  cmd;
	sbh_stat_t stat;

	// Controller: takes a beat only when idle. A data byte goes straight into
	// the block window; the last byte of a block starts 80 rounds. An end beat
	// then walks the padding: 0x80, zeros up to byte 56, length high byte first.
	sbh_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (bytes.valid),
		.in_byte_present (bytes.byte_present),
		.in_eom          (bytes.end_of_message),
		.in_ready        (bytes.ready),
		.stat            (stat),
		.cmd             (cmd)
	);

	// Datapath: the 512-bit window doubles as byte packer and rolling
	// message schedule. The finished digest is copied into a five-word
	// buffer, so the chaining words return to their initial values at once
	// and the next message can start while earlier digest beats wait.
	sbh_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (bytes.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.digest_word (digest.digest_word),
		.word_number (digest.word_number),
		.last_word   (digest.last_word)
	);

endmodule

`default_nettype wire

FILE: src/sbh_checker.sv
// Port-level checks on the digest channel of the hasher, bound to the top level.
// Depends on sha1_byte_stream_hasher_defines.svh and sha1_byte_stream_hasher.
`default_nettype none
`include "sha1_byte_stream_hasher_defines.svh"

module sbh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_number,
	input wire logic        last_word
);

	// a stalled beat stays offered with the same word
	`SBH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digest_word))

	// last flag marks exactly the fifth word
	`SBH_ASSERT_NOW(a_last_pos, out_valid, last_word == (word_number == 3'd4))

	// digest words come back to back, numbered in order
	`SBH_ASSERT_NEXT(a_word_seq, out_valid && out_ready && !last_word,
		out_valid && (word_number == 3'($past(word_number) + 3'd1)))

	// a new digest always starts at word zero
	`SBH_ASSERT_NEXT(a_first_word, !out_valid || (out_ready && last_word),
		!out_valid || (word_number == 3'd0))

endmodule

bind sha1_byte_stream_hasher sbh_checker u_sbh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_number (digest.word_number),
	.last_word   (digest.last_word)
);

`default_nettype wire

FILE: sim/tb_sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha1_byte_stream_hasher: byte beats in, digest word beats out.
// Depends on the RTL interfaces in sbh_channels.sv and on the hasher top level.

module tb_sha1_byte_stream_hasher;

	// SHA-1 round constants and initial chaining value, kept local to the predictor
	localparam logic [31:0] RC_CH  = 32'h5A827999;
	localparam logic [31:0] RC_PAR = 32'h6ED9EBA1;
	localparam logic [31:0] RC_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] RC_END = 32'hCA62C1D6;
	localparam logic [31:0] IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	// worst quiet stretch is an end beat that needs two compressions
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 350;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic clk;
	logic arst_n;

	sbh_byte_if   byte_ch ();
	sbh_digest_if digest_ch ();

	sha1_byte_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.digest (digest_ch)
	);

	// hash state of the predictor
	logic [31:0] sha_chain [5];
	logic [31:0] msg_block [16];
	logic [5:0]  fill_pos;
	logic [63:0] msg_bits;

	digest_beat_t digest_due [$];

	int error_count = 0;
	int items_sent = 0;
	int gap_pct = 0;	// chance of a sender gap before a beat
	int stall_pct = 0;	// chance of a receiver stall burst
	bit quiet = 0;		// no idling at all in the closing part

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void restart_hash();
		int i;
		for (i = 0; i < 5; i++)
			sha_chain[i] = IV[i];
		for (i = 0; i < 16; i++)
			msg_block[i] = '0;
		fill_pos = '0;
		msg_bits = '0;
	endfunction

	// 80 rounds with a rolling 16-word schedule, then the chaining add
	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, sum;
		int t;
		w = msg_block;
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (t = 0; t < 80; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = rotl(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15], 1);
				w[t & 15] = wt;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = RC_CH;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = RC_PAR;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RC_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = RC_END;
			end
			sum = rotl(a, 5) + f + e + wt + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = sum;
		end
		sha_chain[0] += a;
		sha_chain[1] += b;
		sha_chain[2] += c;
		sha_chain[3] += d;
		sha_chain[4] += e;
	endfunction

	// big-endian packing; a full block triggers compression
	function automatic void absorb_byte(input logic [7:0] value);
		logic [3:0] idx;
		idx = fill_pos[5:2];
		msg_block[idx] = {msg_block[idx][23:0], value};
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			compress_block();
	endfunction

	// one accepted input beat; an end beat pads, queues the five digest words and restarts
	function automatic void predict_beat(input logic [7:0] value, input logic present,
			input logic eom);
		logic [63:0] length_bits;
		int i;
		if (present) begin
			absorb_byte(value);
			msg_bits += 64'd8;
		end
		if (!eom)
			return;
		length_bits = msg_bits;
		absorb_byte(PAD_MARK);
		while (fill_pos != LEN_OFFSET)
			absorb_byte(8'h00);
		for (i = 7; i >= 0; i--)
			absorb_byte(length_bits[8 * i +: 8]);
		for (i = 0; i < 5; i++)
			digest_due.push_back('{sha_chain[i], 3'(i), i == 4});
		restart_hash();
	endfunction

	// ---------------------------------------------------------------------------
	// Monitors: outputs sampled at the rising edge, inputs driven at the falling edge
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			predict_beat(byte_ch.data_byte, byte_ch.byte_present, byte_ch.end_of_message);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : check_digest
		digest_beat_t want;
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			if (digest_due.size() == 0) begin
				report_mismatch("unexpected digest beat", digest_ch.digest_word, '0);
			end else begin
				want = digest_due.pop_front();
				if (digest_ch.digest_word !== want.word)
					report_mismatch("digest_word", digest_ch.digest_word, want.word);
				if (digest_ch.word_number !== want.index)
					report_mismatch("word_number", 32'(digest_ch.word_number), 32'(want.index));
				if (digest_ch.last_word !== want.last)
					report_mismatch("last_word", 32'(digest_ch.last_word), 32'(want.last));
			end
		end
	end

	// watchdog: cycles with no beat accepted on either side
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (digest_ch.valid && digest_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// digest receiver: random stall bursts
	initial begin : digest_receiver
		int stall_left;
		stall_left = 0;
		digest_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !quiet) begin
				digest_ch.ready = 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				digest_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				digest_ch.ready = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------

	// one input beat, held until accepted; valid stays high into the next beat
	task automatic send_beat(input logic [7:0] value, input logic present, input logic eom);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = value;
		byte_ch.byte_present = present;
		byte_ch.end_of_message = eom;
		do @(posedge clk); while (!byte_ch.ready);
		if (present || eom)
			items_sent++;
	endtask

	// random message; the end rides on the last byte or comes as a byte-less beat
	task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) && end_on_byte);
		end
		if (len == 0 || !end_on_byte)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_empty_message();
		gap_pct = 0;
		stall_pct = 0;
		send_beat(8'h00, 1'b0, 1'b1);
	endtask

	// "abc" with the end on its last byte, then extreme byte values with a separate end
	task automatic test_short_messages();
		gap_pct = 20;
		stall_pct = 20;
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b1);
	endtask

	// beats with neither byte nor end must leave the hash untouched
	task automatic test_empty_beats();
		gap_pct = 10;
		stall_pct = 10;
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'h5A, 1'b1, 1'b0);
		send_beat(8'hC3, 1'b0, 1'b0);
		send_beat(8'h3C, 1'b1, 1'b1);
	endtask

	// ends arriving while the previous digest still drains
	task automatic test_back_to_back_ends();
		gap_pct = 0;
		stall_pct = 40;
		send_beat(8'h12, 1'b0, 1'b1);
		send_beat(8'h34, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h80, 1'b1, 1'b1);
	endtask

	// mostly short messages, some around the padding boundaries and past one block
	task automatic test_random_messages();
		int len, pick, start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				len = $urandom_range(0, 12);
			else if (pick <= 7)
				len = $urandom_range(54, 66);
			else if (pick == 8)
				len = $urandom_range(100, 130);
			else
				len = $urandom_range(118, 121);
			// some messages run with no idling at all
			if ($urandom_range(0, 3) == 0) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			send_message(len, $urandom_range(0, 1), $urandom_range(0, 10));
		end
	endtask

	// closing part: full rate on both sides, including a long message
	task automatic test_full_rate_tail();
		quiet = 1;
		send_message($urandom_range(1, 8), 1'b1, 0);
		send_message(64, 1'b0, 0);
		send_message($urandom_range(55, 56), 1'b1, 0);
		send_message(0, 1'b0, 0);
	endtask

	initial begin
		restart_hash();
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.byte_present = 1'b0;
		byte_ch.end_of_message = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_short_messages();
		test_empty_beats();
		test_back_to_back_ends();
		test_random_messages();
		test_full_rate_tail();

		@(negedge clk);
		byte_ch.valid = 1'b0;

		// drain, then watch a little longer for stray beats
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/sbh_pkg.sv
src/sbh_channels.sv
src/sbh_ctrl.sv
src/sbh_datapath.sv
src/sha1_byte_stream_hasher.sv
src/sbh_checker.sv
sim/tb_sha1_byte_stream_hasher.sv
